### sv/hcb_pkg.sv
package hcb_pkg;

  localparam int HCB_MAX_SYMBOLS = 1024;
  localparam int HCB_CODE_WIDTH  = 32;
  localparam int HCB_STACK_DEPTH = 1024;

  localparam int FUNC_W         = 2;
  localparam int SYMBOL_W       = 10;
  localparam int FREQ_W         = 32;
  localparam int ENTRY_W        = 32;
  localparam int STATUS_W       = 2;
  localparam int SYMBOL_COUNT_W = 11;
  localparam int LEN_BYTE_W     = 8;

  localparam logic [SYMBOL_COUNT_W-1:0] SYMBOL_COUNT_RESET = 11'd1024;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_BUILD = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LONG  = 2'd2;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stk_status_t;

endpackage

### sv/hcb_in_if.sv
interface hcb_in_if import hcb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [SYMBOL_W-1:0] symbol;
  logic [FREQ_W-1:0]   frequency;

  modport source (output valid, func, symbol, frequency, input ready);
  modport sink   (input valid, func, symbol, frequency, output ready);
endinterface

### sv/hcb_out_if.sv
interface hcb_out_if import hcb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ENTRY_W-1:0]  code_entry;
  logic                entry_valid;
  logic [STATUS_W-1:0] status;

  modport source (output valid, code_entry, entry_valid, status, input ready);
  modport sink   (input valid, code_entry, entry_valid, status, output ready);
endinterface

### sv/huffman_codebook_builder.sv
// Channel  Dir  Beat payload                              Accepted when
// in_i     in   func, symbol, frequency                   valid & ready
// out_o    out  code_entry, entry_valid, status           valid & ready
// cfg      in   cfg_wdata_i (symbol_count)                cfg_we_i
//
// Frequency writes and codebook reads are taken back to back while results
// are consumed. A build holds the input while it scans every symbol, sifts
// each heap insert and removal one level per read and check state pair, and
// walks every tree node; the registered memory reads set this pace. After
// reset all MAX_SYMBOLS frequency and codebook entries are cleared one at a time,
// during which no beat is accepted. A stalled result blocks new beats.
module huffman_codebook_builder import hcb_pkg::*; #(
  parameter int MAX_SYMBOLS = HCB_MAX_SYMBOLS,
  parameter int CODE_WIDTH  = HCB_CODE_WIDTH,
  parameter int STACK_DEPTH = HCB_STACK_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [SYMBOL_COUNT_W-1:0] cfg_wdata_i,
  hcb_in_if.sink                    in_i,
  hcb_out_if.source                 out_o
);

  localparam int SW  = $clog2(MAX_SYMBOLS);
  localparam int HW  = $clog2(MAX_SYMBOLS + 1);
  localparam int NW  = $clog2(2 * MAX_SYMBOLS);
  localparam int WW  = FREQ_W + SW;
  localparam int LW  = (SW + 1 > LEN_BYTE_W) ? SW + 1 : LEN_BYTE_W;
  localparam int HEW = WW + NW;
  localparam int NEW = 1 + 2 * NW + SW;
  localparam int SEW = NW + CODE_WIDTH + LW;
  localparam int CBW = CODE_WIDTH + 1;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_SCAN, S_SCAN_CHK, S_INS_RD, S_INS_CHK, S_MERGE,
    S_REM_RD, S_REM_TAKE, S_DN_RD, S_DN_CHK, S_JOIN, S_ROOT_RD, S_ROOT_TAKE,
    S_WALK_RD, S_WALK_CHK, S_DONE
  } state_e;

  state_e                    state_q;
  logic [SW-1:0]             s_q;
  logic [HW-1:0]             cnt_q, i_q;
  logic [NW-1:0]             nused_q, cur_q, x_n_q, a_n_q, b_n_q;
  logic [WW-1:0]             x_w_q, a_w_q, b_w_q;
  logic                      ret_scan_q, first_q, too_long_q;
  logic [CODE_WIDTH-1:0]     path_q;
  logic [LW-1:0]             len_q;
  logic [STATUS_W-1:0]       status_q;
  logic [SYMBOL_COUNT_W-1:0] sc_q;
  logic                      out_valid_q, kind_read_q, oor_q;

  logic [FREQ_W-1:0] freq_mem [MAX_SYMBOLS];
  logic [CBW-1:0]    cb_mem   [MAX_SYMBOLS];
  logic [HEW-1:0]    heap_mem [MAX_SYMBOLS + 1];
  logic [NEW-1:0]    node_mem [2 * MAX_SYMBOLS];

  logic [FREQ_W-1:0] frd_q;
  logic [CBW-1:0]    cbrd_q;
  logic [HEW-1:0]    hrd_a_q, hrd_b_q;
  logic [NEW-1:0]    nrd_q;

  logic              accept, sym_oor;
  func_e             func;
  logic [16:0]       sym_ext;
  logic [SW-1:0]     sym_addr;

  logic              freq_we, cb_we, heap_we, node_we;
  logic [SW-1:0]     freq_wa, cb_wa;
  logic [FREQ_W-1:0] freq_wd;
  logic [CBW-1:0]    cb_wd;
  logic [HW-1:0]     heap_wa, heap_ra, heap_rb;
  logic [HEW-1:0]    heap_wd;
  logic [NW-1:0]     node_wa;
  logic [NEW-1:0]    node_wd;

  logic [HW:0]       l_idx, l1_idx;
  logic              l_le, l1_le, pick_b, sink_more, parent_ok, is_leaf_cand, scan_last;
  logic [HEW-1:0]    x_e, c_e;
  logic [WW-1:0]     hrd_a_w, hrd_b_w, c_w;
  logic [HW-1:0]     c_idx;

  logic              nd_leaf;
  logic [NW-1:0]     nd_left, nd_right;
  logic [SW-1:0]     nd_sym;
  logic              len_long;
  logic [CODE_WIDTH-1:0] word;

  stk_ctrl_t         stk_ctrl;
  stk_status_t       stk_status;
  logic [SEW-1:0]    stk_top;
  logic [NW-1:0]     top_right;
  logic [CODE_WIDTH-1:0] top_path;
  logic [LW-1:0]     top_len;

  logic              show;
  logic [63:0]       cb_ext;

  assign func     = func_e'(in_i.func);
  assign sym_ext  = 17'(in_i.symbol);
  assign sym_addr = sym_ext[SW-1:0];
  assign sym_oor  = 32'(in_i.symbol) >= 32'(MAX_SYMBOLS);

  assign in_i.ready = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  assign x_e     = {x_w_q, x_n_q};
  assign hrd_a_w = hrd_a_q[HEW-1:NW];
  assign hrd_b_w = hrd_b_q[HEW-1:NW];

  // Children of heap slot i sit at 2i and 2i+1; the right one counts only
  // while it is inside the heap.
  assign l_idx     = {i_q, 1'b0};
  assign l1_idx    = l_idx + (HW + 1)'(1);
  assign l_le      = l_idx <= {1'b0, cnt_q};
  assign l1_le     = l1_idx <= {1'b0, cnt_q};
  assign pick_b    = l1_le && (hrd_b_w < hrd_a_w);
  assign c_e       = pick_b ? hrd_b_q : hrd_a_q;
  assign c_w       = c_e[HEW-1:NW];
  assign c_idx     = pick_b ? l1_idx[HW-1:0] : l_idx[HW-1:0];
  assign sink_more = x_w_q > c_w;
  assign parent_ok = hrd_a_w <= x_w_q;

  assign is_leaf_cand = (32'(s_q) < 32'(sc_q)) && (frd_q != '0);
  assign scan_last    = s_q == SW'(MAX_SYMBOLS - 1);

  assign nd_leaf  = nrd_q[NEW-1];
  assign nd_left  = nrd_q[NEW-2 -: NW];
  assign nd_right = nrd_q[NW+SW-1 -: NW];
  assign nd_sym   = nrd_q[SW-1:0];
  assign len_long = 32'(len_q) > 32'(CODE_WIDTH - LEN_BYTE_W);
  assign word     = path_q | {len_q[LEN_BYTE_W-1:0], {(CODE_WIDTH-LEN_BYTE_W){1'b0}}};

  assign top_right = stk_top[SEW-1 -: NW];
  assign top_path  = stk_top[CODE_WIDTH+LW-1 -: CODE_WIDTH];
  assign top_len   = stk_top[LW-1:0];

  assign stk_ctrl.push = (state_q == S_WALK_CHK) && !nd_leaf;
  assign stk_ctrl.pop  = (state_q == S_WALK_CHK) && nd_leaf;

  hcb_stack #(.DEPTH(STACK_DEPTH), .WIDTH(SEW)) u_stack (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (stk_ctrl),
    .data_i   ({nd_right, path_q, len_q}),
    .top_o    (stk_top),
    .status_o (stk_status)
  );

  // Memory port control.
  always_comb begin
    freq_we = 1'b0;
    freq_wa = s_q;
    freq_wd = '0;
    cb_we   = 1'b0;
    cb_wa   = s_q;
    cb_wd   = '0;
    heap_we = 1'b0;
    heap_wa = i_q;
    heap_wd = x_e;
    heap_ra = '0;
    heap_rb = '0;
    node_we = 1'b0;
    node_wa = nused_q;
    node_wd = {1'b1, {(2*NW){1'b0}}, s_q};
    unique case (state_q)
      S_INIT, S_SCAN: begin
        freq_we = 1'b1;
        cb_we   = 1'b1;
      end
      S_IDLE: begin
        freq_we = accept && (func == FUNC_WRITE) && !sym_oor;
        freq_wa = sym_addr;
        freq_wd = in_i.frequency;
      end
      S_SCAN_CHK: begin
        node_we = is_leaf_cand;
      end
      S_INS_RD: begin
        heap_ra = i_q >> 1;
        heap_we = i_q <= HW'(1);
      end
      S_INS_CHK: begin
        heap_we = 1'b1;
        heap_wd = parent_ok ? x_e : hrd_a_q;
      end
      S_REM_RD: begin
        heap_ra = HW'(1);
        heap_rb = cnt_q;
      end
      S_DN_RD: begin
        heap_ra = l_le ? l_idx[HW-1:0] : HW'(1);
        heap_rb = l1_le ? l1_idx[HW-1:0] : heap_ra;
        heap_we = !l_le;
      end
      S_DN_CHK: begin
        heap_we = 1'b1;
        heap_wd = sink_more ? c_e : x_e;
      end
      S_JOIN: begin
        node_we = 1'b1;
        node_wd = {1'b0, a_n_q, b_n_q, {SW{1'b0}}};
      end
      S_ROOT_RD: begin
        heap_ra = HW'(1);
      end
      S_WALK_CHK: begin
        cb_we = nd_leaf;
        cb_wa = nd_sym;
        cb_wd = {1'b1, word};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (freq_we) begin
      freq_mem[freq_wa] <= freq_wd;
    end
    frd_q <= freq_mem[s_q];
  end

  always_ff @(posedge clk_i) begin
    if (cb_we) begin
      cb_mem[cb_wa] <= cb_wd;
    end
    if (accept && (func == FUNC_READ)) begin
      cbrd_q <= cb_mem[sym_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (heap_we) begin
      heap_mem[heap_wa] <= heap_wd;
    end
    hrd_a_q <= heap_mem[heap_ra];
    hrd_b_q <= heap_mem[heap_rb];
  end

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    nrd_q <= node_mem[cur_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      s_q         <= '0;
      cnt_q       <= '0;
      i_q         <= '0;
      nused_q     <= '0;
      cur_q       <= '0;
      x_n_q       <= '0;
      x_w_q       <= '0;
      a_n_q       <= '0;
      a_w_q       <= '0;
      b_n_q       <= '0;
      b_w_q       <= '0;
      ret_scan_q  <= 1'b0;
      first_q     <= 1'b0;
      too_long_q  <= 1'b0;
      path_q      <= '0;
      len_q       <= '0;
      status_q    <= STATUS_OK;
      sc_q        <= SYMBOL_COUNT_RESET;
      out_valid_q <= 1'b0;
      kind_read_q <= 1'b0;
      oor_q       <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        sc_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_INIT: begin
          s_q <= s_q + SW'(1);
          if (scan_last) begin
            s_q     <= '0;
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            unique case (func)
              FUNC_BUILD: begin
                s_q        <= '0;
                cnt_q      <= '0;
                nused_q    <= '0;
                too_long_q <= 1'b0;
                state_q    <= S_SCAN;
              end
              FUNC_READ: begin
                out_valid_q <= 1'b1;
                kind_read_q <= 1'b1;
                oor_q       <= sym_oor;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          state_q <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (is_leaf_cand) begin
            x_w_q      <= WW'(frd_q);
            x_n_q      <= nused_q;
            nused_q    <= nused_q + NW'(1);
            cnt_q      <= cnt_q + HW'(1);
            i_q        <= cnt_q + HW'(1);
            ret_scan_q <= 1'b1;
            state_q    <= S_INS_RD;
          end else if (scan_last) begin
            state_q <= S_MERGE;
          end else begin
            s_q     <= s_q + SW'(1);
            state_q <= S_SCAN;
          end
        end
        S_INS_RD, S_INS_CHK: begin
          if ((state_q == S_INS_RD && i_q <= HW'(1)) ||
              (state_q == S_INS_CHK && parent_ok)) begin
            if (!ret_scan_q) begin
              state_q <= S_MERGE;
            end else if (scan_last) begin
              state_q <= S_MERGE;
            end else begin
              s_q     <= s_q + SW'(1);
              state_q <= S_SCAN;
            end
          end else if (state_q == S_INS_RD) begin
            state_q <= S_INS_CHK;
          end else begin
            i_q     <= i_q >> 1;
            state_q <= S_INS_RD;
          end
        end
        S_MERGE: begin
          if (cnt_q == '0) begin
            status_q <= STATUS_EMPTY;
            state_q  <= S_DONE;
          end else if (cnt_q > HW'(1)) begin
            first_q <= 1'b1;
            state_q <= S_REM_RD;
          end else begin
            state_q <= S_ROOT_RD;
          end
        end
        S_REM_RD: begin
          state_q <= S_REM_TAKE;
        end
        S_REM_TAKE: begin
          if (first_q) begin
            a_w_q <= hrd_a_w;
            a_n_q <= hrd_a_q[NW-1:0];
          end else begin
            b_w_q <= hrd_a_w;
            b_n_q <= hrd_a_q[NW-1:0];
          end
          x_w_q   <= hrd_b_w;
          x_n_q   <= hrd_b_q[NW-1:0];
          cnt_q   <= cnt_q - HW'(1);
          i_q     <= HW'(1);
          state_q <= S_DN_RD;
        end
        S_DN_RD, S_DN_CHK: begin
          if ((state_q == S_DN_RD && !l_le) || (state_q == S_DN_CHK && !sink_more)) begin
            if (first_q) begin
              first_q <= 1'b0;
              state_q <= S_REM_RD;
            end else begin
              state_q <= S_JOIN;
            end
          end else if (state_q == S_DN_RD) begin
            state_q <= S_DN_CHK;
          end else begin
            i_q     <= c_idx;
            state_q <= S_DN_RD;
          end
        end
        S_JOIN: begin
          x_w_q      <= a_w_q + b_w_q;
          x_n_q      <= nused_q;
          nused_q    <= nused_q + NW'(1);
          cnt_q      <= cnt_q + HW'(1);
          i_q        <= cnt_q + HW'(1);
          ret_scan_q <= 1'b0;
          state_q    <= S_INS_RD;
        end
        S_ROOT_RD: begin
          state_q <= S_ROOT_TAKE;
        end
        S_ROOT_TAKE: begin
          cur_q   <= hrd_a_q[NW-1:0];
          path_q  <= '0;
          len_q   <= '0;
          state_q <= S_WALK_RD;
        end
        S_WALK_RD: begin
          state_q <= S_WALK_CHK;
        end
        S_WALK_CHK: begin
          state_q <= S_WALK_RD;
          if (!nd_leaf) begin
            cur_q  <= nd_left;
            path_q <= path_q << 1;
            len_q  <= len_q + LW'(1);
          end else begin
            too_long_q <= too_long_q | len_long;
            if (stk_status.empty) begin
              status_q <= (too_long_q | len_long) ? STATUS_LONG : STATUS_OK;
              state_q  <= S_DONE;
            end else begin
              cur_q  <= top_right;
              path_q <= (top_path << 1) | CODE_WIDTH'(1);
              len_q  <= top_len + LW'(1);
            end
          end
        end
        S_DONE: begin
          out_valid_q <= 1'b1;
          kind_read_q <= 1'b0;
          oor_q       <= 1'b0;
          state_q     <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign show   = kind_read_q && !oor_q;
  assign cb_ext = 64'(cbrd_q[CODE_WIDTH-1:0]);

  assign out_o.valid       = out_valid_q;
  assign out_o.code_entry  = show ? cb_ext[ENTRY_W-1:0] : '0;
  assign out_o.entry_valid = show && cbrd_q[CODE_WIDTH];
  assign out_o.status      = status_q;

  a_heap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= MAX_SYMBOLS)
    else $error("heap count above symbol capacity");

  a_build_clears_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func == FUNC_BUILD) |=> !out_valid_q)
    else $error("result pending while a build runs");

  a_walk_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK_CHK && nd_leaf && stk_status.empty) |=> state_q == S_DONE)
    else $error("tree walk did not finish on an empty stack");

  a_sift_up_parent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_CHK) |-> (i_q > HW'(1)))
    else $error("sift-up compared the root against itself");

endmodule

### sv/hcb_stack_cell.sv
module hcb_stack_cell #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             push_i,
  input  logic             pop_i,
  input  logic [WIDTH-1:0] above_i,
  input  logic [WIDTH-1:0] below_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] entry_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q <= above_i;
    end else if (pop_i) begin
      entry_q <= below_i;
    end
  end

  assign q_o = entry_q;

endmodule

### sv/hcb_stack.sv
module hcb_stack import hcb_pkg::*; #(
  parameter int DEPTH = HCB_STACK_DEPTH,
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stk_ctrl_t        ctrl_i,
  input  logic [WIDTH-1:0] data_i,
  output logic [WIDTH-1:0] top_o,
  output stk_status_t      status_o
);

  localparam int SPW = $clog2(DEPTH + 1);

  logic [SPW-1:0]   sp_q, sp_d;
  logic             do_push, do_pop;
  logic [WIDTH-1:0] chain [DEPTH];

  // A push onto a full stack is dropped and leaves every cell as it was.
  assign status_o.full  = (sp_q == SPW'(DEPTH));
  assign status_o.empty = (sp_q == '0);
  assign do_push = ctrl_i.push && !status_o.full;
  assign do_pop  = ctrl_i.pop && !status_o.empty;

  always_comb begin
    sp_d = sp_q;
    if (do_push) begin
      sp_d = sp_q + SPW'(1);
    end else if (do_pop) begin
      sp_d = sp_q - SPW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else begin
      sp_q <= sp_d;
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [WIDTH-1:0] above, below;
    if (k == 0) begin : g_first
      assign above = data_i;
    end else begin : g_inner
      assign above = chain[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_body
      assign below = chain[k+1];
    end
    hcb_stack_cell #(.WIDTH(WIDTH)) u_cell (
      .clk_i   (clk_i),
      .push_i  (do_push),
      .pop_i   (do_pop),
      .above_i (above),
      .below_i (below),
      .q_o     (chain[k])
    );
  end

  assign top_o = chain[0];

endmodule

### verif/tb_huffman_codebook_builder.sv
module tb_huffman_codebook_builder;
  import hcb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int NODES = 2 * HCB_MAX_SYMBOLS;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int TARGET_ITEMS = 2000;

  typedef struct {
    logic [ENTRY_W-1:0]  code_entry;
    logic                entry_valid;
    logic [STATUS_W-1:0] status;
  } entry_t;

  class codebook_scoreboard;
    logic [FREQ_W-1:0]  freq_mem[HCB_MAX_SYMBOLS];
    logic [ENTRY_W-1:0] book_word[HCB_MAX_SYMBOLS];
    bit                 book_ok[HCB_MAX_SYMBOLS];
    logic [STATUS_W-1:0] last_status;
    int unsigned        sym_limit;
    entry_t             pending_entries[$];
    int unsigned        mismatches;

    longint unsigned    weight[NODES];
    int unsigned        lchild[NODES];
    int unsigned        rchild[NODES];
    int unsigned        leaf_sym[NODES];
    bit                 is_leaf[NODES];
    int unsigned        heap[HCB_MAX_SYMBOLS+1];
    int unsigned        heap_n;
    int unsigned        stk_node[HCB_STACK_DEPTH];
    longint unsigned    stk_path[HCB_STACK_DEPTH];
    int unsigned        stk_len[HCB_STACK_DEPTH];

    function new();
      foreach (freq_mem[i]) begin
        freq_mem[i] = '0;
        book_word[i] = '0;
        book_ok[i] = 0;
      end
      last_status = STATUS_OK;
      sym_limit = HCB_MAX_SYMBOLS;
      mismatches = 0;
    endfunction

    function void set_symbol_count(logic [SYMBOL_COUNT_W-1:0] v);
      sym_limit = (v > HCB_MAX_SYMBOLS) ? HCB_MAX_SYMBOLS : v;
    endfunction

    function void heap_push(int unsigned n);
      int unsigned i, j;
      if (heap_n >= HCB_MAX_SYMBOLS) return;
      heap_n++;
      i = heap_n;
      while (i > 1) begin
        j = i >> 1;
        if (weight[heap[j]] <= weight[n]) break;
        heap[i] = heap[j];
        i = j;
      end
      heap[i] = n;
    endfunction

    function int unsigned heap_pop();
      int unsigned top, i, l, t;
      top = heap[1];
      i = 1;
      heap[1] = heap[heap_n];
      heap_n--;
      while ((i << 1) <= heap_n) begin
        l = i << 1;
        if (l + 1 <= heap_n && weight[heap[l+1]] < weight[heap[l]]) l++;
        if (weight[heap[i]] > weight[heap[l]]) begin
          t = heap[i];
          heap[i] = heap[l];
          heap[l] = t;
          i = l;
        end else begin
          break;
        end
      end
      return top;
    endfunction

    function void build_codebook();
      int unsigned used, a, b, n, cur, sp, len, s;
      longint unsigned path;
      bit too_long;
      used = 0;
      heap_n = 0;
      too_long = 0;
      foreach (book_word[i]) begin
        book_word[i] = '0;
        book_ok[i] = 0;
      end
      for (s = 0; s < sym_limit; s++) begin
        if (freq_mem[s] != 0) begin
          n = used++;
          weight[n] = freq_mem[s];
          leaf_sym[n] = s;
          is_leaf[n] = 1;
          heap_push(n);
        end
      end
      foreach (freq_mem[i]) freq_mem[i] = '0;
      if (heap_n == 0) begin
        last_status = STATUS_EMPTY;
        return;
      end
      while (heap_n > 1) begin
        a = heap_pop();
        b = heap_pop();
        n = used++;
        lchild[n] = a;
        rchild[n] = b;
        weight[n] = weight[a] + weight[b];
        is_leaf[n] = 0;
        heap_push(n);
      end
      // Depth-first walk; the path is kept to the code width like the hardware.
      cur = heap[1];
      path = 0;
      len = 0;
      sp = 0;
      forever begin
        if (!is_leaf[cur]) begin
          if (sp < HCB_STACK_DEPTH) begin
            stk_node[sp] = cur;
            stk_path[sp] = path;
            stk_len[sp] = len;
            sp++;
          end
          cur = lchild[cur];
          path = (path << 1) & 64'hffff_ffff;
          len++;
        end else begin
          s = leaf_sym[cur] % HCB_MAX_SYMBOLS;
          book_word[s] = path[31:0] | (ENTRY_W'(len & 8'hff) << (ENTRY_W - LEN_BYTE_W));
          book_ok[s] = 1;
          if (len > HCB_CODE_WIDTH - LEN_BYTE_W) too_long = 1;
          if (sp == 0) break;
          sp--;
          cur = rchild[stk_node[sp]];
          path = ((stk_path[sp] << 1) | 1) & 64'hffff_ffff;
          len = stk_len[sp] + 1;
        end
      end
      last_status = too_long ? STATUS_LONG : STATUS_OK;
    endfunction

    function void note_input(logic [FUNC_W-1:0] f, logic [SYMBOL_W-1:0] s,
                             logic [FREQ_W-1:0] q);
      entry_t e;
      case (f)
        FUNC_WRITE: freq_mem[s] = q;
        FUNC_BUILD: begin
          build_codebook();
          e.code_entry = '0;
          e.entry_valid = 0;
          e.status = last_status;
          pending_entries.push_back(e);
        end
        FUNC_READ: begin
          e.code_entry = book_word[s];
          e.entry_valid = book_ok[s];
          e.status = last_status;
          pending_entries.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [ENTRY_W-1:0] c, logic v, logic [STATUS_W-1:0] st);
      entry_t e;
      if (pending_entries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: code_entry=%h entry_valid=%b status=%0d", c, v, st);
        return;
      end
      e = pending_entries.pop_front();
      if (c !== e.code_entry || v !== e.entry_valid || st !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %h/%b/%0d, got %h/%b/%0d",
                   e.code_entry, e.entry_valid, e.status, c, v, st);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [SYMBOL_COUNT_W-1:0] cfg_wdata_i = '0;

  hcb_in_if  in_ch();
  hcb_out_if out_ch();

  huffman_codebook_builder u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  codebook_scoreboard book = new();
  bit fast_mode = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      book.check_result(out_ch.code_entry, out_ch.entry_valid, out_ch.status);
      results_seen++;
    end
  end

  // Result side: random stalls, plus one long hold-off while input keeps coming.
  initial begin
    int unsigned n;
    bit held;
    held = 0;
    out_ch.ready = 0;
    @(posedge rst_ni);
    forever begin
      if (!held && results_seen >= 150) begin
        held = 1;
        out_ch.ready <= 0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      n = fast_mode ? 0 : $urandom_range(16);
      if (n > 0) begin
        out_ch.ready <= 0;
        repeat (n) @(posedge clk_i);
      end
      out_ch.ready <= 1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  task automatic send_item(logic [FUNC_W-1:0] f, logic [SYMBOL_W-1:0] s,
                           logic [FREQ_W-1:0] q);
    int unsigned gap;
    gap = fast_mode ? 0 : $urandom_range(16);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1;
    in_ch.func <= f;
    in_ch.symbol <= s;
    in_ch.frequency <= q;
    do @(posedge clk_i); while (!in_ch.ready);
    book.note_input(f, s, q);
    items_sent++;
  endtask

  task automatic write_symbol_count(logic [SYMBOL_COUNT_W-1:0] v);
    in_ch.valid <= 0;
    @(posedge clk_i);
    while (book.pending_entries.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    book.set_symbol_count(v);
  endtask

  function automatic logic [FREQ_W-1:0] pick_freq();
    case ($urandom_range(3))
      0: return $urandom_range(15);
      1: return $urandom;
      2: return 32'hffff_ffff;
      default: return $urandom_range(1000, 1);
    endcase
  endfunction

  // Writes a handful of frequencies, builds, then reads back a few entries.
  task automatic random_phase(int unsigned writes, int unsigned reads);
    logic [SYMBOL_W-1:0] s;
    repeat (writes) begin
      s = ($urandom_range(3) == 0) ? SYMBOL_W'($urandom) : SYMBOL_W'($urandom_range(63));
      if ($urandom_range(15) == 0) send_item(FUNC_UNUSED, s, $urandom);
      else send_item(FUNC_WRITE, s, pick_freq());
    end
    send_item(FUNC_BUILD, SYMBOL_W'($urandom), $urandom);
    repeat (reads) begin
      s = ($urandom_range(3) == 0) ? SYMBOL_W'($urandom) : SYMBOL_W'($urandom_range(63));
      send_item(FUNC_READ, s, $urandom);
    end
  endtask

  initial begin
    logic [FREQ_W-1:0] fa, fb, ft;
    logic [SYMBOL_COUNT_W-1:0] cnt;
    in_ch.valid = 0;
    in_ch.func = FUNC_WRITE;
    in_ch.symbol = '0;
    in_ch.frequency = '0;
    rst_ni = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;

    write_symbol_count(SYMBOL_COUNT_RESET);
    // Reads before any build, then an empty build.
    send_item(FUNC_READ, 10'd0, '0);
    send_item(FUNC_READ, 10'd1023, 32'hffff_ffff);
    send_item(FUNC_UNUSED, 10'd5, 32'h1234_5678);
    send_item(FUNC_BUILD, '0, '0);
    send_item(FUNC_READ, 10'd7, '0);
    // A single symbol gets a zero-length code.
    send_item(FUNC_WRITE, 10'd1023, 32'hffff_ffff);
    send_item(FUNC_BUILD, '0, '0);
    send_item(FUNC_READ, 10'd1023, '0);
    // Three symbols written, one of them at or above symbol_count.
    write_symbol_count(11'd2);
    send_item(FUNC_WRITE, 10'd0, 32'd3);
    send_item(FUNC_WRITE, 10'd1, 32'd3);
    send_item(FUNC_WRITE, 10'd2, 32'd9);
    send_item(FUNC_WRITE, 10'd1, 32'd0);
    send_item(FUNC_WRITE, 10'd1, 32'd5);
    send_item(FUNC_BUILD, '0, '0);
    send_item(FUNC_READ, 10'd0, '0);
    send_item(FUNC_READ, 10'd1, '0);
    send_item(FUNC_READ, 10'd2, '0);

    // Fibonacci weights give a deep tree whose codes overflow the word.
    write_symbol_count(11'd2047);
    fa = 1;
    fb = 1;
    for (int i = 0; i < 45; i++) begin
      send_item(FUNC_WRITE, SYMBOL_W'(i), fa);
      ft = fa + fb;
      fa = fb;
      fb = ft;
    end
    send_item(FUNC_BUILD, '0, '0);
    for (int i = 0; i < 45; i += 4) send_item(FUNC_READ, SYMBOL_W'(i), '0);
    send_item(FUNC_READ, 10'd44, '0);

    // One full-size build over every symbol.
    write_symbol_count(SYMBOL_COUNT_RESET);
    fast_mode = 1;
    for (int i = 0; i < HCB_MAX_SYMBOLS; i++) send_item(FUNC_WRITE, SYMBOL_W'(i), pick_freq());
    send_item(FUNC_BUILD, '0, '0);
    for (int i = 0; i < 40; i++) send_item(FUNC_READ, SYMBOL_W'($urandom), '0);
    fast_mode = 0;

    while (items_sent < TARGET_ITEMS) begin
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(4))
          0: cnt = 11'd1;
          1: cnt = 11'd2047;
          2: cnt = 11'd1024;
          default: cnt = SYMBOL_COUNT_W'($urandom_range(1024, 1));
        endcase
        write_symbol_count(cnt);
      end
      fast_mode = ($urandom_range(3) == 0);
      random_phase($urandom_range(30), $urandom_range(24, 4));
    end
    in_ch.valid <= 0;
    fast_mode = 0;

    while (book.pending_entries.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (book.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
